// ===== design/pwq_pkg.sv =====
package pwq_pkg;

  // Widths of the fixed request and result fields.
  localparam int ID_BITS     = 8;
  localparam int PRIO_BITS   = 8;
  localparam int KIND_BITS   = 2;
  localparam int OCC_BITS    = 5;
  localparam int MAX_ENTRIES = 16;

  typedef enum logic [KIND_BITS-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] req_type;
    logic [ID_BITS-1:0]   task_id;
    logic [PRIO_BITS-1:0] priority_req;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic                 was_present;
    logic [OCC_BITS-1:0]  occupancy;
    logic                 best_valid;
    logic [ID_BITS-1:0]   best_task;
    logic [PRIO_BITS-1:0] best_priority;
  } rsp_t;

  // Contents of one queue slot.
  typedef struct packed {
    logic                 valid;
    logic [ID_BITS-1:0]   task_id;
    logic [PRIO_BITS-1:0] prio;
  } slot_t;

  // A request as it travels down the chain, with what it has learnt so far.
  typedef struct packed {
    logic                 active;
    logic [KIND_BITS-1:0] kind;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    logic                 found;
    logic                 placed;
    logic                 best_valid;
    logic [ID_BITS-1:0]   best_task;
    logic [PRIO_BITS-1:0] best_prio;
  } wave_t;

endpackage

// ===== design/pwq_cell.sv =====
module pwq_cell (
  input  logic          clk,
  input  logic          rst,
  input  pwq_pkg::wave_t wave_in,
  output pwq_pkg::wave_t wave_out,
  input  pwq_pkg::slot_t next_slot,
  output pwq_pkg::slot_t slot
);
  import pwq_pkg::*;

  slot_t slot_next;
  wave_t wave_next;
  logic  match;
  logic  shift;
  logic  place;
  logic  better;

  always_comb begin
    match = slot.valid && (slot.task_id == wave_in.id);
    // Once the named task has been passed, every later slot closes the gap.
    shift = wave_in.active && (wave_in.kind == REQ_REMOVE) && (wave_in.found || match);
    // Slots are filled from the front, so the first empty one is the tail.
    place = wave_in.active && (wave_in.kind == REQ_ADD) && !wave_in.found &&
            !wave_in.placed && !slot.valid;

    if (shift) begin
      slot_next = next_slot;
    end else if (place) begin
      slot_next = '{valid: 1'b1, task_id: wave_in.id, prio: wave_in.prio};
    end else begin
      slot_next = slot;
    end

    // Strict compare keeps the earliest arrival on equal priorities.
    better = slot_next.valid && (!wave_in.best_valid || (slot_next.prio < wave_in.best_prio));

    wave_next        = wave_in;
    wave_next.found  = wave_in.found || match;
    wave_next.placed = wave_in.placed || place;
    if (better) begin
      wave_next.best_valid = 1'b1;
      wave_next.best_task  = slot_next.task_id;
      wave_next.best_prio  = slot_next.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid      <= 1'b0;
      wave_out.active <= 1'b0;
    end else begin
      slot.valid      <= slot_next.valid;
      wave_out.active <= wave_next.active;
    end
  end

  always_ff @(posedge clk) begin
    slot.task_id        <= slot_next.task_id;
    slot.prio           <= slot_next.prio;
    wave_out.kind       <= wave_next.kind;
    wave_out.id         <= wave_next.id;
    wave_out.prio       <= wave_next.prio;
    wave_out.found      <= wave_next.found;
    wave_out.placed     <= wave_next.placed;
    wave_out.best_valid <= wave_next.best_valid;
    wave_out.best_task  <= wave_next.best_task;
    wave_out.best_prio  <= wave_next.best_prio;
  end

endmodule

// ===== design/priority_wait_queue.sv =====
// Priority wait queue. Tasks wait in arrival order in a row of MAX_ENTRIES slot cells. A
// request (add at tail, remove by task id, or membership query) is taken at an edge where
// start is high and busy is low. Each request travels down the cell row one cell per cycle.
// Done and the result are registered from the request as it leaves the last cell. Done is
// high for exactly one cycle, and the result is taken at the edge that ends that cycle.
// Busy is high from the accepting edge until the request has left the last cell, so only
// one request is ever in the row. The next request can be accepted at the same edge that
// takes the previous result, so a new request is not taken before the previous one is
// through the row. Results come out in request order and the receiver cannot stall them, so
// it must sample every cycle in which done is high. Each result gives
// the status of the request, whether the task was queued beforehand, the occupancy
// afterwards and the most urgent waiter (lowest priority number, earliest arrival on ties),
// which reads as zero when the queue is empty.
module priority_wait_queue #(
  parameter int MAX_ENTRIES = pwq_pkg::MAX_ENTRIES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  pwq_pkg::req_t request,
  output logic          done,
  output pwq_pkg::rsp_t result
);
  import pwq_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // waves[k] is the request arriving at cell k; waves[MAX_ENTRIES] has passed every cell.
  wave_t waves [MAX_ENTRIES+1];
  slot_t slots [MAX_ENTRIES];

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [CNT_W+OCC_BITS-1:0] occ_wide;
  rsp_t                      rsp_next;
  wave_t                     tail;
  logic                      pending;

  // A removal pulls each slot from its right-hand neighbour before the request reaches that
  // neighbour, so a second request in the row would read slots that the first has not yet
  // settled. A request is therefore held off while another is still in the row.
  assign busy = pending;

  always_comb begin
    waves[0]            = '0;
    waves[0].active     = start && !busy;
    waves[0].kind       = request.req_type;
    waves[0].id         = request.task_id;
    waves[0].prio       = request.priority_req;
  end

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    slot_t nb;
    // The last cell takes an empty slot when the queue closes up behind a removal.
    if (k == MAX_ENTRIES - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = slots[k+1];
    end

    pwq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wave_in  (waves[k]),
      .wave_out (waves[k+1]),
      .next_slot(nb),
      .slot     (slots[k])
    );
  end

  // Results are formed once the request has left the last cell.
  always_comb begin
    tail       = waves[MAX_ENTRIES];
    count_next = count;
    if (tail.active && tail.placed) begin
      count_next = count + CNT_W'(1);
    end else if (tail.active && (tail.kind == REQ_REMOVE) && tail.found) begin
      count_next = count - CNT_W'(1);
    end

    rsp_next = '0;
    case (tail.kind)
      REQ_ADD: begin
        if (tail.found) begin
          rsp_next.status = ST_DUPLICATE;
        end else if (tail.placed) begin
          rsp_next.status = ST_OK;
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      default: begin
        // Removals, queries and the unused request code all report membership.
        rsp_next.status = tail.found ? ST_OK : ST_NOT_FOUND;
      end
    endcase

    // Occupancy is reported in a fixed five-bit field.
    occ_wide                = {{OCC_BITS{1'b0}}, count_next};
    rsp_next.was_present    = tail.found;
    rsp_next.occupancy      = occ_wide[OCC_BITS-1:0];
    rsp_next.best_valid     = tail.best_valid;
    rsp_next.best_task      = tail.best_task;
    rsp_next.best_priority  = tail.best_prio;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      done    <= 1'b0;
      pending <= 1'b0;
    end else begin
      count <= count_next;
      done  <= tail.active;
      // Set when a request enters the row, cleared as it leaves the last cell.
      if (waves[0].active) begin
        pending <= 1'b1;
      end else if (tail.active) begin
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= rsp_next;
  end

  // The queue never holds more tasks than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("occupancy exceeds the number of slots");

  // A best waiter is reported exactly when tasks remain queued.
  a_best_matches_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.best_valid == (count != '0)))
    else $error("best waiter flag disagrees with occupancy");

  // An empty queue reports a zero task and priority.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.best_valid) |-> (result.best_task == '0 && result.best_priority == '0))
    else $error("empty queue reports a non-zero best waiter");

  // Occupied slots stay packed at the front: the second slot is empty whenever the first is.
  a_packed_front: assert property (@(posedge clk) disable iff (rst)
    !slots[0].valid |-> !slots[1].valid)
    else $error("gap found at the front of the slot row");

endmodule
